@@ rtl/dlr_pkg.sv @@
package dlr_pkg;

    localparam int PIX_W = 6;

endpackage

@@ rtl/dda_line_rasterizer_top.sv @@
// dda line rasterizer
//
// input channel: one request carries both endpoints of a line (i_start_x,
// i_start_y, i_end_x, i_end_y). It is taken when i_in_valid is high and
// o_in_stall is low. o_in_stall stays high from the cycle after a request
// until the last pixel of that line has been loaded into the output register.
//
// output channel: one pixel per transfer on o_pixel_x / o_pixel_y, walking
// along the major axis in ascending order. o_last_pixel marks the final one.
// A pixel is taken when o_out_valid is high and i_out_stall is low.
//
// timing: the request is registered as setup, then the slope division runs on
// one shared restoring subtract/compare unit at one quotient bit per cycle,
// for FRAC_BITS + 1 quotient bits. After that the walk loads one pixel per
// cycle while the receiver does not stall, for 1 to 2^COORD_BITS pixels.
// While the receiver stalls, the output register holds its pixel and the walk
// waits. The last pixel may still wait in the output register while the next
// request is taken.
//
// reset: i_rst_n low clears the sequencer and the output valid flag.
module dda_line_rasterizer_top
    import dlr_pkg::*;
#(
    parameter int COORD_BITS = 6,
    parameter int FRAC_BITS  = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [PIX_W-1:0] i_start_x,
    input  logic [PIX_W-1:0] i_start_y,
    input  logic [PIX_W-1:0] i_end_x,
    input  logic [PIX_W-1:0] i_end_y,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [PIX_W-1:0] o_pixel_x,
    output logic [PIX_W-1:0] o_pixel_y,
    output logic             o_last_pixel
);

    localparam int AW    = COORD_BITS + FRAC_BITS + 2;
    localparam int CNT_W = $clog2(FRAC_BITS + 1);
    localparam logic [AW-1:0] HALF = AW'(1) << (FRAC_BITS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_WALK
    } t_state;

    t_state                 r_state;
    logic                   r_xmajor;
    logic                   r_neg;
    logic [COORD_BITS-1:0]  r_major;
    logic [COORD_BITS-1:0]  r_end;
    logic [COORD_BITS:0]    r_rem;
    logic [COORD_BITS-1:0]  r_den;
    logic [FRAC_BITS:0]     r_quo;
    logic [CNT_W-1:0]       r_cnt;
    logic signed [AW-1:0]   r_acc;
    logic                   r_out_valid;
    logic [PIX_W-1:0]       r_px;
    logic [PIX_W-1:0]       r_py;
    logic                   r_last;

    // setup from the request
    logic [COORD_BITS-1:0] sx, sy, ex, ey;
    logic [COORD_BITS-1:0] adx, ady;
    logic                  xneg, yneg, xmaj;
    logic [COORD_BITS-1:0] n_major, n_end, n_minor, n_num, n_den;

    always_comb begin
        sx   = i_start_x[COORD_BITS-1:0];
        sy   = i_start_y[COORD_BITS-1:0];
        ex   = i_end_x[COORD_BITS-1:0];
        ey   = i_end_y[COORD_BITS-1:0];
        xneg = sx > ex;
        yneg = sy > ey;
        adx  = xneg ? sx - ex : ex - sx;
        ady  = yneg ? sy - ey : ey - sy;
        xmaj = (adx != '0) && (ady < adx);
        if (xmaj) begin
            n_major = xneg ? ex : sx;
            n_end   = xneg ? sx : ex;
            n_minor = xneg ? ey : sy;
            n_num   = ady;
            n_den   = adx;
        end else begin
            n_major = yneg ? ey : sy;
            n_end   = yneg ? sy : ey;
            n_minor = yneg ? ex : sx;
            n_num   = adx;
            n_den   = ady;
        end
    end

    // shared divider step
    logic                trial;
    logic [COORD_BITS:0] rem_after;

    always_comb begin
        trial     = (r_den != '0) && (r_rem >= {1'b0, r_den});
        rem_after = trial ? r_rem - {1'b0, r_den} : r_rem;
    end

    // walk datapath
    logic signed [AW-1:0]  inc_ext;
    logic signed [AW-1:0]  n_acc;
    logic [AW-1:0]         rsum;
    logic [COORD_BITS-1:0] minor_pix;
    logic                  at_end;

    always_comb begin
        inc_ext = {{(AW - FRAC_BITS - 1){1'b0}}, r_quo};
        n_acc   = r_neg ? r_acc - inc_ext : r_acc + inc_ext;
        rsum    = r_acc + HALF;
        // round half up, clamp to the grid
        if (r_acc[AW-1]) begin
            minor_pix = '0;
        end else if (rsum[AW-1:FRAC_BITS+COORD_BITS] != '0) begin
            minor_pix = '1;
        end else begin
            minor_pix = rsum[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
        end
        at_end = r_major == r_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && r_state != ST_WALK) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_xmajor <= xmaj;
                        r_neg    <= xneg ^ yneg;
                        r_major  <= n_major;
                        r_end    <= n_end;
                        r_rem    <= {1'b0, n_num};
                        r_den    <= n_den;
                        r_cnt    <= '0;
                        r_acc    <= {2'b00, n_minor, {FRAC_BITS{1'b0}}};
                        r_state  <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_quo <= {r_quo[FRAC_BITS-1:0], trial};
                    r_rem <= {rem_after[COORD_BITS-1:0], 1'b0};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(FRAC_BITS)) begin
                        r_state <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_px        <= PIX_W'(r_xmajor ? r_major : minor_pix);
                        r_py        <= PIX_W'(r_xmajor ? minor_pix : r_major);
                        r_last      <= at_end;
                        r_major     <= r_major + 1'b1;
                        r_acc       <= n_acc;
                        if (at_end) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall   = r_state != ST_IDLE;
    assign o_out_valid  = r_out_valid;
    assign o_pixel_x    = r_px;
    assign o_pixel_y    = r_py;
    assign o_last_pixel = r_last;

endmodule

@@ rtl/dlr_checker.sv @@
module dlr_checker
    import dlr_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input logic [PIX_W-1:0] o_pixel_x,
    input logic [PIX_W-1:0] o_pixel_y,
    input logic             o_last_pixel
);

    // a stalled pixel holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_pixel_x) && $stable(o_pixel_y) && $stable(o_last_pixel))
        else $error("stalled pixel changed");

    // a line in progress keeps the input closed
    a_busy_mid_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_pixel |-> o_in_stall)
        else $error("request taken while a line is still being drawn");

    // a taken request closes the input on the next cycle
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not closed after a request");

    // the input opens only after a last pixel has been produced
    a_open_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_stall) |-> o_out_valid && o_last_pixel)
        else $error("input opened without a last pixel");

endmodule

bind dda_line_rasterizer_top dlr_checker u_dlr_checker (.*);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import dlr_pkg::*;

    localparam int COORD_BITS   = 6;
    localparam int FRAC_BITS    = 16;
    localparam int IDLE_PCT     = 20;
    localparam int QUIET_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 120;
    localparam int MAX_REPORTS  = 10;

    typedef logic [PIX_W-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   last;
    } t_pixel;

    logic   i_clk       = 1'b0;
    logic   i_rst_n     = 1'b0;
    logic   i_in_valid  = 1'b0;
    logic   i_out_stall = 1'b0;
    t_coord i_start_x   = '0;
    t_coord i_start_y   = '0;
    t_coord i_end_x     = '0;
    t_coord i_end_y     = '0;
    logic   o_in_stall;
    logic   o_out_valid;
    t_coord o_pixel_x;
    t_coord o_pixel_y;
    logic   o_last_pixel;

    t_pixel pending_pixels[$];
    int     mismatches    = 0;
    int     quiet_cycles  = 0;
    int     hold_requests = 0;
    int     hold_seen     = 0;
    int     hold_left     = 0;
    bit     steady        = 1'b0;

    dda_line_rasterizer_top #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .i_end_x     (i_end_x),
        .i_end_y     (i_end_y),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_pixel_x   (o_pixel_x),
        .o_pixel_y   (o_pixel_y),
        .o_last_pixel(o_last_pixel)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // walks the line and queues every pixel it should produce
    function automatic void rasterize_line(t_coord sx_in, t_coord sy_in,
                                           t_coord ex_in, t_coord ey_in);
        longint mask;
        longint sx, sy, ex, ey, dx, dy, adx, ady;
        longint lo, hi, minor, num, den, step, acc, rounded, m;
        bit     x_major;
        t_pixel px;
        mask    = (longint'(1) << COORD_BITS) - 1;
        sx      = longint'(sx_in) & mask;
        sy      = longint'(sy_in) & mask;
        ex      = longint'(ex_in) & mask;
        ey      = longint'(ey_in) & mask;
        dx      = ex - sx;
        dy      = ey - sy;
        adx     = (dx < 0) ? -dx : dx;
        ady     = (dy < 0) ? -dy : dy;
        x_major = (dx != 0) && (ady < adx);
        if (x_major) begin
            lo    = (sx > ex) ? ex : sx;
            hi    = (sx > ex) ? sx : ex;
            minor = (sx > ex) ? ey : sy;
            num   = dy;
            den   = dx;
        end else begin
            lo    = (sy > ey) ? ey : sy;
            hi    = (sy > ey) ? sy : ey;
            minor = (sy > ey) ? ex : sx;
            num   = dx;
            den   = dy;
        end
        if (den == 0) begin
            step = 0;
        end else begin
            step = (((num < 0) ? -num : num) << FRAC_BITS) / ((den < 0) ? -den : den);
            if ((num < 0) != (den < 0)) begin
                step = -step;
            end
        end
        acc = minor << FRAC_BITS;
        for (m = lo; m <= hi; m++) begin
            if (acc < 0) begin
                rounded = 0;
            end else begin
                rounded = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
                if (rounded > mask) begin
                    rounded = mask;
                end
            end
            px.x    = t_coord'(x_major ? (m & mask) : (rounded & mask));
            px.y    = t_coord'(x_major ? (rounded & mask) : (m & mask));
            px.last = (m == hi);
            pending_pixels.push_back(px);
            acc += step;
        end
    endfunction

    task automatic flag_error(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endtask

    // one line request; valid stays high into the next call when there is no gap
    task automatic request_line(input t_coord sx, input t_coord sy,
                                input t_coord ex, input t_coord ey);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_start_x  <= sx;
        i_start_y  <= sy;
        i_end_x    <= ex;
        i_end_y    <= ey;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        rasterize_line(sx, sy, ex, ey);
    endtask

    // receiver side: random stalls, long hold-offs on demand, pixel checks
    always @(posedge i_clk) begin
        t_pixel want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_pixels.size() == 0) begin
                    flag_error($sformatf("unexpected pixel x=%0d y=%0d last=%0b",
                                         o_pixel_x, o_pixel_y, o_last_pixel));
                end else begin
                    want = pending_pixels.pop_front();
                    if (o_pixel_x !== want.x || o_pixel_y !== want.y ||
                        o_last_pixel !== want.last) begin
                        flag_error($sformatf(
                            {"pixel mismatch: expected x=%0d y=%0d last=%0b, ",
                             "got x=%0d y=%0d last=%0b"},
                            want.x, want.y, want.last, o_pixel_x, o_pixel_y, o_last_pixel));
                    end
                end
            end
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left   = hold_left - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // watchdog on cycles with no request taken
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic test_single_points();
        request_line(6'd0, 6'd0, 6'd0, 6'd0);
        request_line(6'd63, 6'd63, 6'd63, 6'd63);
        request_line(6'd21, 6'd42, 6'd21, 6'd42);
    endtask

    task automatic test_axis_lines();
        request_line(6'd0, 6'd0, 6'd63, 6'd0);
        request_line(6'd63, 6'd63, 6'd0, 6'd63);
        request_line(6'd63, 6'd0, 6'd63, 6'd63);
        request_line(6'd0, 6'd63, 6'd0, 6'd0);
        request_line(6'd30, 6'd17, 6'd31, 6'd17);
    endtask

    task automatic test_diagonals();
        request_line(6'd0, 6'd0, 6'd63, 6'd63);
        request_line(6'd63, 6'd63, 6'd0, 6'd0);
        request_line(6'd0, 6'd63, 6'd63, 6'd0);
        request_line(6'd40, 6'd10, 6'd30, 6'd20);
    endtask

    task automatic test_slopes_and_rounding();
        // shallow, steep, both signs, one off equal, and half-way rounding
        request_line(6'd0, 6'd0, 6'd63, 6'd10);
        request_line(6'd63, 6'd5, 6'd0, 6'd40);
        request_line(6'd3, 6'd0, 6'd20, 6'd63);
        request_line(6'd60, 6'd63, 6'd10, 6'd0);
        request_line(6'd0, 6'd0, 6'd10, 6'd9);
        request_line(6'd0, 6'd0, 6'd9, 6'd10);
        request_line(6'd0, 6'd0, 6'd2, 6'd1);
        request_line(6'd0, 6'd1, 6'd2, 6'd0);
        request_line(6'd0, 6'd0, 6'd3, 6'd1);
        request_line(6'd5, 6'd63, 6'd12, 6'd61);
    endtask

    task automatic test_random_lines(input int count);
        int     kind;
        t_coord sx, sy, ex, ey;
        repeat (count) begin
            kind = $urandom_range(99);
            sx   = t_coord'($urandom_range(63));
            sy   = t_coord'($urandom_range(63));
            if (kind < 70) begin
                ex = t_coord'($urandom_range((sx < 7) ? 0 : sx - 7, (sx > 56) ? 63 : sx + 7));
                ey = t_coord'($urandom_range((sy < 7) ? 0 : sy - 7, (sy > 56) ? 63 : sy + 7));
            end else if (kind < 95) begin
                ex = t_coord'($urandom_range(63));
                ey = t_coord'($urandom_range(63));
            end else if (kind < 98) begin
                sx = $urandom_range(1) ? 6'd0 : 6'd63;
                ex = ~sx;
                ey = t_coord'($urandom_range(63));
            end else begin
                sy = $urandom_range(1) ? 6'd0 : 6'd63;
                ey = ~sy;
                ex = t_coord'($urandom_range(63));
            end
            request_line(sx, sy, ex, ey);
        end
    endtask

    task automatic test_unbroken_stream();
        steady = 1'b1;
        test_random_lines(40);
        steady = 1'b0;
    endtask

    task automatic test_output_hold_off();
        hold_requests++;
        test_random_lines(20);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_single_points();
        test_axis_lines();
        test_diagonals();
        test_slopes_and_rounding();
        test_random_lines(200);
        test_output_hold_off();
        test_unbroken_stream();
        test_random_lines(220);
        i_in_valid <= 1'b0;
        while (pending_pixels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
